### hw/rtl/inverse_polynomial_curve_entry_core_assert.svh
// assertion macros for the inverse polynomial curve entry block
`ifndef INVERSE_POLYNOMIAL_CURVE_ENTRY_CORE_ASSERT_SVH
`define INVERSE_POLYNOMIAL_CURVE_ENTRY_CORE_ASSERT_SVH

// checked only outside reset
`define IPC_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("ipc check failed");

// checked at every edge, reset included
`define IPC_ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
	else $error("ipc check failed");

`endif

### hw/rtl/ipc_pkg.sv
// shared types and constants of the inverse polynomial curve entry block
`default_nettype none
package ipc_pkg;
	localparam int MAX_TERMS = 6;
	localparam int CODE_W = 8;
	localparam int ACC_W = 36;
	localparam int COEFF_W = 32;
	localparam int PROD_W = 45;

	localparam logic [2:0] REG_TERM_COUNT = 3'd0;
	localparam logic [2:0] REG_COEFF_0 = 3'd1;
	localparam logic [2:0] REG_COEFF_5 = 3'd6;

	typedef logic [MAX_TERMS-1:0][COEFF_W-1:0] coeff_arr_t;

	typedef struct packed {
		logic vld;
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] lo;
		logic [CODE_W-1:0] mid;
		logic [ACC_W-1:0] acc;
	} beat_t;
endpackage
`default_nettype wire

### hw/rtl/ipc_horner.sv
// one horner step: acc = trunc(acc * mid / 256) + coeff, or zero when the term is unused
`default_nettype none
module ipc_horner (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic [2:0] term_idx,
	input wire logic [2:0] n_terms,
	input wire ipc_pkg::coeff_arr_t coeff,
	input wire ipc_pkg::beat_t in_beat,
	output ipc_pkg::beat_t out_beat
);
	import ipc_pkg::*;

	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] adj;
	logic signed [PROD_W-1:0] quo;
	logic [COEFF_W-1:0] c;
	logic [ACC_W-1:0] acc_nxt;
	beat_t beat_nxt;
	logic vld_s1;
	beat_t dat_s1;

	always_comb begin
		c = coeff[term_idx];
		prod = $signed(in_beat.acc) * $signed({1'b0, in_beat.mid});
		adj = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
		quo = adj >>> 8;
		if (term_idx < n_terms) begin
			acc_nxt = quo[ACC_W-1:0] + {{(ACC_W-COEFF_W){c[COEFF_W-1]}}, c};
		end else begin
			acc_nxt = '0;
		end
		beat_nxt = in_beat;
		beat_nxt.acc = acc_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_beat.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_s1 <= beat_nxt;
		end
	end

	always_comb begin
		out_beat = dat_s1;
		out_beat.vld = vld_s1;
	end
endmodule
`default_nettype wire

### hw/rtl/ipc_cell.sv
// one bisection step: horner evaluation at the midpoint, then compare
`default_nettype none
module ipc_cell (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic [ipc_pkg::CODE_W-1:0] step_bit,
	input wire logic [2:0] n_terms,
	input wire ipc_pkg::coeff_arr_t coeff,
	input wire ipc_pkg::beat_t in_beat,
	output ipc_pkg::beat_t out_beat
);
	import ipc_pkg::*;

	beat_t chain [MAX_TERMS+1];
	beat_t last;
	logic signed [PROD_W-1:0] lhs;
	logic signed [PROD_W-1:0] rhs;
	logic signed [PROD_W-1:0] p_ext;
	logic less;
	logic vld_s1;
	logic [CODE_W-1:0] code_s1;
	logic [CODE_W-1:0] lo_s1;

	always_comb begin
		chain[0] = in_beat;
		chain[0].mid = in_beat.lo | step_bit;
		chain[0].acc = '0;
	end

	for (genvar g = 0; g < MAX_TERMS; g++) begin : g_horner
		ipc_horner u_horner (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.term_idx(3'(MAX_TERMS - 1 - g)),
			.n_terms(n_terms),
			.coeff(coeff),
			.in_beat(chain[g]),
			.out_beat(chain[g+1])
		);
	end

	// i * 2^24 < 255 * P
	always_comb begin
		last = chain[MAX_TERMS];
		p_ext = $signed({{(PROD_W-ACC_W){last.acc[ACC_W-1]}}, last.acc});
		rhs = (p_ext <<< 8) - p_ext;
		lhs = $signed({{(PROD_W-CODE_W-24){1'b0}}, last.code, 24'b0});
		less = lhs < rhs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_s1 <= last.code;
			lo_s1 <= less ? last.lo : last.mid;
		end
	end

	always_comb begin
		out_beat.vld = vld_s1;
		out_beat.code = code_s1;
		out_beat.lo = lo_s1;
		out_beat.mid = lo_s1;
		out_beat.acc = '0;
	end
endmodule
`default_nettype wire

### hw/rtl/inverse_polynomial_curve_entry_core.sv
// top level: chain of eight bisection cells with output register
//
// channel  dir  payload
// s_axis   in   tdata[7:0] target_code
// m_axis   out  tdata[8:0] drive_value
// cfg      in   cfg_index selects term_count or coeff_0..coeff_5
//
// one code accepted per cycle while the output is not stalled (8 cells of 7 stages + output)
// latency is set by the six horner stages and the compare stage of each cell
// reset clears the valid bits and the configuration registers
// a stalled output beat freezes the whole chain; s_axis_tready follows it
`default_nettype none
module inverse_polynomial_curve_entry_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [7:0] s_axis_tdata, // target_code
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [15:0] m_axis_tdata, // drive_value, zeros
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_wdata
);
	import ipc_pkg::*;

	logic [2:0] term_count_q;
	coeff_arr_t coeff_q;
	logic [2:0] n_terms;
	logic en;
	beat_t cells [CODE_W+1];
	logic vld_q;
	logic [CODE_W-1:0] lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= '0;
			coeff_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_TERM_COUNT) begin
				term_count_q <= cfg_wdata[2:0];
			end else if (cfg_index >= REG_COEFF_0 && cfg_index <= REG_COEFF_5) begin
				coeff_q[cfg_index - REG_COEFF_0] <= cfg_wdata;
			end
		end
	end

	assign n_terms = (term_count_q > 3'(MAX_TERMS)) ? 3'(MAX_TERMS) : term_count_q;
	assign en = !vld_q || m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		cells[0].vld = s_axis_tvalid;
		cells[0].code = s_axis_tdata;
		cells[0].lo = '0;
		cells[0].mid = '0;
		cells[0].acc = '0;
	end

	for (genvar s = 0; s < CODE_W; s++) begin : g_cell
		ipc_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.step_bit(CODE_W'(1) << (CODE_W - 1 - s)),
			.n_terms(n_terms),
			.coeff(coeff_q),
			.in_beat(cells[s]),
			.out_beat(cells[s+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= cells[CODE_W].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_q <= cells[CODE_W].lo;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata = {7'b0, lo_q, 1'b1};
endmodule
`default_nettype wire

### hw/rtl/ipc_checker.sv
// port-level checks of the inverse polynomial curve entry block, bound to the top
`default_nettype none
`include "inverse_polynomial_curve_entry_core_assert.svh"
module ipc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [15:0] m_axis_tdata
);
	`IPC_ASSERT(a_odd_drive, m_axis_tvalid |-> m_axis_tdata[0])
	`IPC_ASSERT(a_pad_zero, m_axis_tvalid |-> (m_axis_tdata[15:9] == 7'b0))
	`IPC_ASSERT(a_ready_follows_out, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
	`IPC_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
	`IPC_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !m_axis_tvalid)
endmodule

bind inverse_polynomial_curve_entry_core ipc_checker u_ipc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

### sim/tb_inverse_polynomial_curve_entry_core.sv
// testbench for the inverse polynomial curve entry core: random codes and coefficient sets checked against a bisection predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_inverse_polynomial_curve_entry_core;
	import ipc_pkg::*;

	class curve_scoreboard;
		logic [2:0] term_count;
		longint coeff[MAX_TERMS];
		logic [8:0] expected_drive[$];
		int errors;
		int checked;

		function void clear_regs();
			term_count = 0;
			foreach (coeff[k]) coeff[k] = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] val);
			if (idx == REG_TERM_COUNT)
				term_count = val[2:0];
			else if (idx >= REG_COEFF_0 && idx <= REG_COEFF_5 && idx - 1 < MAX_TERMS)
				coeff[idx - 1] = longint'($signed(val));
		endfunction

		function longint horner_at(int unsigned m);
			int n;
			longint acc;
			n = term_count > MAX_TERMS ? MAX_TERMS : term_count;
			if (n == 0)
				return 0;
			acc = coeff[n - 1];
			for (int k = n - 1; k > 0; k--) begin
				acc = (acc * longint'(m)) / 256;
				acc += coeff[k - 1];
			end
			return acc;
		endfunction

		function void note_code(logic [7:0] code);
			longint lhs;
			int unsigned lo, hi, mid;
			lhs = longint'(code) * 64'sd16777216;
			lo = 0;
			hi = 256;
			for (int s = 0; s < 8; s++) begin
				mid = (lo + hi) / 2;
				if (lhs < 255 * horner_at(mid))
					hi = mid;
				else
					lo = mid;
			end
			expected_drive = {expected_drive, 9'(2 * lo + 1)};
		endfunction

		task check_drive(logic [15:0] data);
			logic [8:0] exp_v;
			if (expected_drive.size() == 0) begin
				report_mismatch($sformatf("unexpected beat %h", data));
				return;
			end
			exp_v = expected_drive.pop_front();
			checked++;
			if (data[8:0] !== exp_v)
				report_mismatch($sformatf("drive_value %0d, expected %0d", data[8:0], exp_v));
			if (data[15:9] !== 7'd0)
				report_mismatch($sformatf("padding bits %h", data[15:9]));
		endtask

		task report_mismatch(string msg);
			errors++;
			$display("mismatch: %s", msg);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [15:0] m_axis_tdata;
	logic cfg_we = 0;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_wdata = 0;

	curve_scoreboard sb;
	int idle_pct = 7;
	int idle_cycles = 0;
	int sent = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	inverse_polynomial_curve_entry_core dut (.*);

	// output side: sample at rising edge, stall at falling edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_drive(m_axis_tdata);
		if (arst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles > 20000) begin
			$display("watchdog expired");
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk)
		if (arst_n)
			m_axis_tready <= ($urandom_range(99) >= idle_pct);

	task automatic write_cfg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic send_code(logic [7:0] code);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= code;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_code(code);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.expected_drive.size() != 0) @(negedge clk);
		repeat (70) @(negedge clk);
	endtask

	// random coefficient set, or all at the extremes
	task automatic load_set(int n, bit extreme);
		logic [31:0] v;
		write_cfg(REG_TERM_COUNT, 32'(n));
		for (int k = 0; k < MAX_TERMS; k++) begin
			if (extreme)
				v = $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			else if ($urandom_range(3) == 0)
				v = $urandom;
			else
				v = 32'(int'($urandom_range(32'h02000000)) - int'(32'h00800000));
			write_cfg(3'(REG_COEFF_0 + k), v);
		end
	endtask

	initial begin
		int n;
		sb = new();
		sb.clear_regs();
		repeat (11) @(negedge clk);
		arst_n <= 1;
		// no terms: every code walks to the top
		send_code(8'd0);
		send_code(8'd255);
		send_code(8'd128);
		drain();
		// gamma-like square law, extremes of code
		write_cfg(REG_TERM_COUNT, 32'd3);
		write_cfg(REG_COEFF_0, 32'd0);
		write_cfg(3'(REG_COEFF_0 + 1), 32'd0);
		write_cfg(3'(REG_COEFF_0 + 2), 32'h01000000);
		foreach (sb.coeff[k]) if (k > 2) write_cfg(3'(REG_COEFF_0 + k), 32'd0);
		for (int i = 0; i < 8; i++) send_code(8'(1 << i));
		send_code(8'd255);
		send_code(8'd0);
		send_code(8'd170);
		send_code(8'd85);
		drain();
		// too many terms, extreme coefficients
		load_set(7, 1);
		send_code(8'd0);
		send_code(8'd255);
		send_code(8'd1);
		drain();
		write_cfg(REG_TERM_COUNT, 32'd6);
		send_code(8'd200);
		send_code(8'd55);
		drain();
		// random phases; one long stretch without idling
		for (int p = 0; p < 18; p++) begin
			idle_pct = (p == 9) ? 0 : 7;
			n = $urandom_range(7);
			load_set(n, $urandom_range(9) == 0);
			for (int j = 0; j < 100; j++) send_code(8'($urandom));
			drain();
		end
		idle_pct = 7;
		$display("covered %0d codes over 22 coefficient settings, %0d results checked",
			sent, sb.checked);
		if (sb.errors == 0 && sb.expected_drive.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
